FILE: rtl/rsd_pkg.sv
// Shared types and constants for the record stream deframer.
`default_nettype none

package rsd_pkg;

  localparam int unsigned SizeBits = 29;
  localparam int unsigned FlagBits = 3;
  localparam logic [31:0] MagicReset = 32'hced7230a;
  localparam logic [FlagBits-1:0] FlagStart = 3'd1;
  localparam logic [FlagBits-1:0] FlagContinue = 3'd2;

  typedef enum logic [2:0] {
    PhHeader  = 3'b001,
    PhPayload = 3'b010,
    PhPad     = 3'b100
  } rsd_phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       record_end;
    logic       bad_magic;
  } rsd_res_t;

endpackage

`default_nettype wire

FILE: rtl/rsd_parser.sv
// Per-byte header, payload and padding parser with its state registers.
`default_nettype none

module rsd_parser import rsd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire logic [31:0] magic_i,
  output logic            res_valid_o,
  output rsd_res_t        res_o
);

  rsd_phase_e          phase_q, phase_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [63:0]         shift_q, shift_d;
  logic [SizeBits-1:0] rem_q, rem_d;
  logic [1:0]          pad_q, pad_d;
  logic                more_q, more_d;

  logic [63:0]         hdr_next;
  logic [31:0]         hdr_magic;
  logic [SizeBits-1:0] hdr_size;
  logic [FlagBits-1:0] hdr_flag;
  logic                hdr_more;

  assign hdr_next  = {byte_i, shift_q[63:8]};
  assign hdr_magic = hdr_next[31:0];
  assign hdr_size  = hdr_next[32 +: SizeBits];
  assign hdr_flag  = hdr_next[63 -: FlagBits];
  assign hdr_more  = (hdr_flag == FlagStart) || (hdr_flag == FlagContinue);

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    shift_d     = shift_q;
    rem_d       = rem_q;
    pad_d       = pad_q;
    more_d      = more_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i) begin
      unique case (phase_q)
        PhPayload: begin
          rem_d             = rem_q - SizeBits'(1);
          res_valid_o       = 1'b1;
          res_o.data_byte   = byte_i;
          res_o.has_data    = 1'b1;
          if (rem_d == '0) begin
            res_o.record_end = ~more_q;
            phase_d          = (pad_q != 2'd0) ? PhPad : PhHeader;
          end
        end
        PhPad: begin
          pad_d = pad_q - 2'd1;
          if (pad_d == 2'd0) begin
            phase_d = PhHeader;
          end
        end
        default: begin
          phase_d = PhHeader;
          shift_d = hdr_next;
          if (cnt_q != 3'd7) begin
            cnt_d = cnt_q + 3'd1;
          end else begin
            cnt_d = 3'd0;
            if (hdr_magic != magic_i) begin
              more_d          = 1'b0;
              res_valid_o     = 1'b1;
              res_o.bad_magic = 1'b1;
            end else begin
              more_d = hdr_more;
              pad_d  = 2'd0 - hdr_size[1:0];
              rem_d  = hdr_size;
              if (hdr_size != '0) begin
                phase_d = PhPayload;
              end else if (!hdr_more) begin
                res_valid_o      = 1'b1;
                res_o.record_end = 1'b1;
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      cnt_q   <= 3'd0;
      shift_q <= '0;
      rem_q   <= '0;
      pad_q   <= 2'd0;
      more_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      rem_q   <= rem_d;
      pad_q   <= pad_d;
      more_q  <= more_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rsd_out_reg.sv
// Result register that holds one result until the receiver takes it.
`default_nettype none

module rsd_out_reg import rsd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  wire rsd_res_t res_i,
  output logic          space_o,
  output logic          valid_o,
  input  wire logic     ready_i,
  output rsd_res_t      res_o
);

  logic     valid_q, valid_d;
  rsd_res_t res_q;

  assign space_o = ~valid_q | ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_comb begin
    valid_d = valid_q & ~ready_i;
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/recordio_stream_deframer.sv
// Top level of the record stream deframer.
//
// Input bytes arrive on a valid/ready channel, one byte per transfer. Each
// record starts with an eight-byte little-endian header: a magic word that
// must match the configured value, then a word with a 29-bit size and a
// 3-bit flag. Payload bytes leave on the output channel with has_data set;
// the last byte of a logical record carries record_end (a data-less result
// does if the last header has size zero). Padding to a four-byte boundary
// is dropped, and a bad magic word gives one result with bad_magic set,
// after which a fresh header is parsed. Each accepted byte is parsed in
// the cycle of its transfer and its result, if any, appears in the result
// register in the next cycle. One byte can be accepted every cycle. While
// a result waits there and the receiver stalls, input is held off; when
// the receiver takes the result, a new byte is accepted in the same cycle.
// Reset empties the result register, returns the parser to the header
// phase and loads the default magic word. The magic register is written
// with cfg_we_i and should only change while the block is idle.
`default_nettype none

module recordio_stream_deframer import rsd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  stream_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       data_byte_o,
  output logic             has_data_o,
  output logic             record_end_o,
  output logic             bad_magic_o
);

  logic [31:0] magic_q;
  logic        step;
  logic        res_valid;
  rsd_res_t    res;
  rsd_res_t    out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= MagicReset;
    end else if (cfg_we_i) begin
      magic_q <= cfg_data_i;
    end
  end

  assign step = in_valid_i & in_ready_o;

  rsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (stream_byte_i),
    .magic_i     (magic_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rsd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step & res_valid),
    .res_i   (res),
    .space_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (out_res)
  );

  assign data_byte_o  = out_res.data_byte;
  assign has_data_o   = out_res.has_data;
  assign record_end_o = out_res.record_end;
  assign bad_magic_o  = out_res.bad_magic;

  a_bad_magic_alone : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_magic_o |-> !has_data_o && !record_end_o && data_byte_o == 8'd0)
    else $error("bad_magic result carries other fields");

  a_empty_is_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_data_o |-> (record_end_o != bad_magic_o) && data_byte_o == 8'd0)
    else $error("result without data is neither end marker nor error");

  a_data_not_bad : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_data_o |-> !bad_magic_o)
    else $error("payload result flagged as bad magic");

endmodule

`default_nettype wire
